>>> design/sihs_pkg.sv
// ============================================================================
// sihs_pkg: shared types, constants and functions for session IV HMAC-SHA256
// Holds the SHA-256 round constants, the initial chain value, the MAC key,
// the derivation tables and the helper functions that are shared by the
// sequencer, the round unit and the top level.
// ============================================================================
package sihs_pkg;

    localparam int KEY_BYTES = 16;

    // Register indexes
    localparam logic [1:0] REG_NONCE_HI   = 2'd0;
    localparam logic [1:0] REG_NONCE_LO   = 2'd1;
    localparam logic [1:0] REG_MORNING_HI = 2'd2;
    localparam logic [1:0] REG_MORNING_LO = 2'd3;

    typedef logic [31:0]      word_t;
    typedef logic [255:0]     state_t;

    // Control from the sequencer to the round unit
    typedef struct packed {
        logic       load;     // load working vars from chain value
        logic       round;    // run one round
        logic       fold;     // add working vars into chain value
        logic [5:0] rnd;      // round number
    } ctl_t;

    localparam logic [7:0] TAB_A [16] = '{
        8'h01, 8'h49, 8'h87, 8'h9b, 8'h65, 8'h39, 8'h8b, 8'h39,
        8'h4b, 8'h3a, 8'h8d, 8'h48, 8'hc3, 8'h0a, 8'hef, 8'h51};
    localparam logic [7:0] TAB_B [16] = '{
        8'he1, 8'hec, 8'h9c, 8'h3a, 8'hdd, 8'hbd, 8'h08, 8'h85,
        8'hfc, 8'h0e, 8'h1d, 8'h78, 8'h90, 8'h32, 8'hc0, 8'h04};

    localparam word_t RK [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,
        32'h3956c25b,32'h59f111f1,32'h923f82a4,32'hab1c5ed5,
        32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,
        32'he49b69c1,32'hefbe4786,32'h0fc19dc6,32'h240ca1cc,
        32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,
        32'hc6e00bf3,32'hd5a79147,32'h06ca6351,32'h14292967,
        32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,
        32'ha2bfe8a1,32'ha81a664b,32'hc24b8b70,32'hc76c51a3,
        32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,
        32'h391c0cb3,32'h4ed8aa4a,32'h5b9cca4f,32'h682e6ff3,
        32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

    localparam state_t H_INIT = {
        32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
        32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};

    localparam logic [127:0] MAC_KEY = 128'hac078883c83a1fe811463af39ee3e377;

    // Message word t of the padded key block (ipad or opad byte replicated)
    function automatic word_t pad_word(input logic [3:0] t, input logic [7:0] pad);
        word_t w;
        w = {4{pad}};
        if (t < 4'd4)
            w = MAC_KEY[127 - 32*t -: 32] ^ w;
        return w;
    endfunction

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Ambassador bytes from the nonce
    function automatic logic [127:0] derive_amb(input logic [127:0] nonce);
        logic [127:0] r;
        logic [7:0]   v;
        for (int i = 0; i < KEY_BYTES; i++) begin
            v = nonce[127 - 8*i -: 8] - 8'(i) - 8'h27;
            r[127 - 8*i -: 8] = v ^ TAB_A[i];
        end
        return r;
    endfunction

    // Bright bytes from morning and nonce
    function automatic logic [127:0] derive_bright(input logic [127:0] morning,
                                                   input logic [127:0] nonce);
        logic [127:0] r;
        logic [7:0]   v;
        for (int i = 0; i < KEY_BYTES; i++) begin
            v = morning[127 - 8*i -: 8] - 8'(i) + 8'h34;
            r[127 - 8*i -: 8] = v ^ TAB_B[i] ^ nonce[127 - 8*i -: 8];
        end
        return r;
    endfunction

endpackage

>>> design/sihs_round.sv
// ============================================================================
// sihs_round: shared SHA-256 round unit
// One compression round per cycle while ctl.round is set, a rolling
// 16-word schedule window and the chain value. Driven by the sequencer.
// ============================================================================
module sihs_round
(
    input  logic            clk,
    input  logic            rst_n,
    input  sihs_pkg::ctl_t  ctl,
    input  logic            chain_load,
    input  sihs_pkg::state_t chain_in,
    input  sihs_pkg::word_t msg_word,
    output sihs_pkg::state_t chain
);

    sihs_pkg::word_t  v_reg [8];
    sihs_pkg::word_t  v_next [8];
    sihs_pkg::word_t  w_reg [16];
    sihs_pkg::state_t h_reg;
    sihs_pkg::state_t h_next;
    sihs_pkg::word_t  wt, s0w, s1w, s0, s1, ch, maj, t1, t2;

    // Schedule word: block data for the first 16 rounds, expansion after
    always_comb
    begin
        s0w = sihs_pkg::rotr(w_reg[1], 7) ^ sihs_pkg::rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1w = sihs_pkg::rotr(w_reg[14], 17) ^ sihs_pkg::rotr(w_reg[14], 19)
            ^ (w_reg[14] >> 10);
        if (ctl.rnd < 6'd16)
            wt = msg_word;
        else
            wt = w_reg[0] + s0w + w_reg[9] + s1w;
    end

    // Round function
    always_comb
    begin
        s1  = sihs_pkg::rotr(v_reg[4], 6) ^ sihs_pkg::rotr(v_reg[4], 11)
            ^ sihs_pkg::rotr(v_reg[4], 25);
        ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1  = v_reg[7] + s1 + ch + sihs_pkg::RK[ctl.rnd] + wt;
        s0  = sihs_pkg::rotr(v_reg[0], 2) ^ sihs_pkg::rotr(v_reg[0], 13)
            ^ sihs_pkg::rotr(v_reg[0], 22);
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2  = s0 + maj;
    end

    // Select next working vars and chain value
    always_comb
    begin
        v_next = v_reg;
        h_next = h_reg;
        if (chain_load)
            h_next = chain_in;
        if (ctl.load) begin
            // a fresh chain value seeds the working vars directly
            for (int j = 0; j < 8; j++)
                v_next[j] = chain_load ? chain_in[255 - 32*j -: 32]
                                       : h_reg[255 - 32*j -: 32];
        end else if (ctl.round) begin
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
        end
        if (ctl.fold) begin
            for (int j = 0; j < 8; j++)
                h_next[255 - 32*j -: 32] = h_reg[255 - 32*j -: 32] + v_reg[j];
        end
    end

    // Hold working vars and chain value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int j = 0; j < 8; j++)
                v_reg[j] <= '0;
            h_reg <= '0;
        end else begin
            v_reg <= v_next;
            h_reg <= h_next;
        end
    end

    // Shift the schedule window once per round
    always_ff @(posedge clk)
    begin
        if (ctl.round) begin
            for (int j = 0; j < 15; j++)
                w_reg[j] <= w_reg[j+1];
            w_reg[15] <= wt;
        end
    end

    assign chain = h_reg;

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.load && ctl.round)) else $error("load and round together");
    a_fold: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fold |-> !ctl.round && !ctl.load) else $error("fold during round");
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fold |-> $past(ctl.round) && $past(ctl.rnd) == 6'd63)
        else $error("fold not after last round");

endmodule

>>> design/sihs_seq.sv
// ============================================================================
// sihs_seq: sequencer for the four compressions of one transaction
// Steps: inner key block, inner data block, outer key block, outer data
// block. Each is a load state, 64 rounds and a fold state.
// ============================================================================
module sihs_seq
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [127:0]     amb,
    input  logic [63:0]      counter,
    input  sihs_pkg::state_t chain,
    output sihs_pkg::ctl_t   ctl,
    output logic             chain_load,
    output sihs_pkg::state_t chain_in,
    output sihs_pkg::word_t  msg_word,
    output logic             busy,
    output logic             done
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LOAD  = 2'd1;
    localparam logic [1:0] ST_ROUND = 2'd2;
    localparam logic [1:0] ST_FOLD  = 2'd3;

    logic [1:0]       st_reg, st_next;
    logic [1:0]       blk_reg, blk_next;
    logic [5:0]       rnd_reg, rnd_next;
    logic [191:0]     data_reg;
    sihs_pkg::state_t inner_reg;
    logic             done_reg, done_next;

    // Message word of the current block
    always_comb
    begin
        unique case (blk_reg)
            2'd0: msg_word = sihs_pkg::pad_word(rnd_reg[3:0], 8'h36);
            2'd2: msg_word = sihs_pkg::pad_word(rnd_reg[3:0], 8'h5c);
            2'd1:
                priority if (rnd_reg[3:0] < 4'd6)
                    msg_word = data_reg[191 - 32*rnd_reg[2:0] -: 32];
                else if (rnd_reg[3:0] == 4'd6)
                    msg_word = 32'h8000_0000;
                else if (rnd_reg[3:0] == 4'd15)
                    msg_word = 32'd704;
                else
                    msg_word = '0;
            default:
                priority if (rnd_reg[3:0] < 4'd8)
                    msg_word = inner_reg[255 - 32*rnd_reg[2:0] -: 32];
                else if (rnd_reg[3:0] == 4'd8)
                    msg_word = 32'h8000_0000;
                else if (rnd_reg[3:0] == 4'd15)
                    msg_word = 32'd768;
                else
                    msg_word = '0;
        endcase
    end

    // Sequence the blocks
    always_comb
    begin
        st_next    = st_reg;
        blk_next   = blk_reg;
        rnd_next   = rnd_reg;
        done_next  = 1'b0;
        chain_load = 1'b0;
        chain_in   = sihs_pkg::H_INIT;
        ctl        = '0;
        ctl.rnd    = rnd_reg;
        unique case (st_reg)
            ST_IDLE:
                if (start) begin
                    chain_load = 1'b1;
                    blk_next   = 2'd0;
                    st_next    = ST_LOAD;
                end
            ST_LOAD:
            begin
                ctl.load = 1'b1;
                rnd_next = '0;
                st_next  = ST_ROUND;
                // restart the chain for the outer hash
                if (blk_reg == 2'd2)
                    chain_load = 1'b1;
            end
            ST_ROUND:
            begin
                ctl.round = 1'b1;
                rnd_next  = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                    st_next = ST_FOLD;
            end
            default:
            begin
                ctl.fold = 1'b1;
                blk_next = blk_reg + 2'd1;
                st_next  = ST_LOAD;
                if (blk_reg == 2'd3) begin
                    st_next   = ST_IDLE;
                    done_next = 1'b1;
                end
            end
        endcase
    end

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg   <= ST_IDLE;
            blk_reg  <= '0;
            rnd_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            st_reg   <= st_next;
            blk_reg  <= blk_next;
            rnd_reg  <= rnd_next;
            done_reg <= done_next;
        end
    end

    // Capture message data; keep the inner digest once the inner fold is done
    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE && start)
            data_reg <= {amb, counter};
        if (st_reg == ST_LOAD && blk_reg == 2'd2)
            inner_reg <= chain;
    end

    assign busy = (st_reg != ST_IDLE);
    assign done = done_reg;

    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while busy");
    a_rnd: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == ST_LOAD |=> st_reg == ST_ROUND && rnd_reg == 6'd0)
        else $error("round count not cleared");
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("start not taken");

endmodule

>>> design/session_iv_hmac_sha256.sv
// ============================================================================
// session_iv_hmac_sha256: session IV generator on HMAC-SHA256
// Derives ambassador and bright values from nonce and morning registers and
// returns the first 16 digest bytes of HMAC over ambassador and counter.
//
// channel   signals                               direction
// config    psel penable pwrite paddr pwdata ...  in, APB, 64-bit data
// command   start busy counter                    in, busy out
// result    done iv_hi iv_lo bright_hi bright_lo  out, one-cycle strobe
//
// A transaction runs four SHA-256 compressions through one shared round
// unit, each a load step, 64 rounds and a fold step, and ends with the
// done strobe; the next start is taken in the strobe cycle.
// busy stays high from the cycle after start through the last fold cycle;
// done is one cycle. Reset clears all configuration to zero; results
// cannot be stalled.
// ============================================================================
module session_iv_hmac_sha256
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        start,
    input  logic [63:0] counter,
    output logic        busy,
    output logic        done,
    output logic [63:0] iv_hi,
    output logic [63:0] iv_lo,
    output logic [63:0] bright_hi,
    output logic [63:0] bright_lo
);

    logic [63:0]      cfg_reg [4];
    logic             wr_en;
    logic [127:0]     amb;
    logic [127:0]     bright;
    sihs_pkg::ctl_t   ctl;
    logic             chain_load;
    sihs_pkg::state_t chain_in;
    sihs_pkg::state_t chain;
    sihs_pkg::word_t  msg_word;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int j = 0; j < 4; j++)
                cfg_reg[j] <= '0;
        end else if (wr_en) begin
            cfg_reg[paddr[4:3]] <= pwdata;
        end
    end

    // Derive the ambassador from the nonce
    assign amb = sihs_pkg::derive_amb({cfg_reg[sihs_pkg::REG_NONCE_HI],
                                       cfg_reg[sihs_pkg::REG_NONCE_LO]});

    assign prdata = cfg_reg[paddr[4:3]];
    assign bright = sihs_pkg::derive_bright(
        {cfg_reg[sihs_pkg::REG_MORNING_HI], cfg_reg[sihs_pkg::REG_MORNING_LO]},
        {cfg_reg[sihs_pkg::REG_NONCE_HI], cfg_reg[sihs_pkg::REG_NONCE_LO]});

    sihs_seq u_seq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .amb        (amb),
        .counter    (counter),
        .chain      (chain),
        .ctl        (ctl),
        .chain_load (chain_load),
        .chain_in   (chain_in),
        .msg_word   (msg_word),
        .busy       (busy),
        .done       (done)
    );

    sihs_round u_round
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .chain_load (chain_load),
        .chain_in   (chain_in),
        .msg_word   (msg_word),
        .chain      (chain)
    );

    assign iv_hi     = chain[255:192];
    assign iv_lo     = chain[191:128];
    assign bright_hi = bright[127:64];
    assign bright_lo = bright[63:0];

endmodule

>>> tb/tb.sv
// ============================================================================
// tb: self-checking testbench for session_iv_hmac_sha256
// Writes nonce and morning registers over APB, issues counter commands and
// checks every strobed IV and bright value against an HMAC-SHA256 predictor
// held in a small scoreboard class.
// ============================================================================
module tb;

    localparam int ITEMS_PER_PHASE = 250;
    localparam int NUM_PHASES      = 8;
    localparam int CYCLE_LIMIT     = 2000000;
    localparam int DRAIN_CYCLES    = 300;

    typedef struct {
        logic [63:0] iv_hi;
        logic [63:0] iv_lo;
        logic [63:0] bright_hi;
        logic [63:0] bright_lo;
    } iv_result_t;

    // ------------------------------------------------------------------------
    // IV scoreboard: own copy of the registers and the HMAC predictor
    // ------------------------------------------------------------------------
    class iv_scoreboard;
        logic [127:0] nonce;
        logic [127:0] morning;
        iv_result_t   pending_ivs[$];
        int           errors;
        int           checked;

        localparam logic [7:0] AMB_TAB [16] = '{
            8'h01, 8'h49, 8'h87, 8'h9b, 8'h65, 8'h39, 8'h8b, 8'h39,
            8'h4b, 8'h3a, 8'h8d, 8'h48, 8'hc3, 8'h0a, 8'hef, 8'h51};
        localparam logic [7:0] BRIGHT_TAB [16] = '{
            8'he1, 8'hec, 8'h9c, 8'h3a, 8'hdd, 8'hbd, 8'h08, 8'h85,
            8'hfc, 8'h0e, 8'h1d, 8'h78, 8'h90, 8'h32, 8'hc0, 8'h04};
        localparam logic [127:0] SECRET_KEY = 128'hac078883c83a1fe811463af39ee3e377;

        function void clear_regs();
            nonce   = '0;
            morning = '0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [63:0] val);
            case (idx)
                sihs_pkg::REG_NONCE_HI:   nonce[127:64]   = val;
                sihs_pkg::REG_NONCE_LO:   nonce[63:0]     = val;
                sihs_pkg::REG_MORNING_HI: morning[127:64] = val;
                sihs_pkg::REG_MORNING_LO: morning[63:0]   = val;
            endcase
        endfunction

        function logic [31:0] ror32(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        // One SHA-256 compression of a 512-bit block into the chain value
        function logic [255:0] sha_block(logic [255:0] chain, logic [511:0] blk);
            logic [31:0] w [64];
            logic [31:0] v [8];
            logic [31:0] s0, s1, t1, t2;
            for (int t = 0; t < 16; t++)
                w[t] = blk[511 - 32*t -: 32];
            for (int t = 16; t < 64; t++) begin
                s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
                s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
                w[t] = w[t-16] + s0 + w[t-7] + s1;
            end
            for (int j = 0; j < 8; j++)
                v[j] = chain[255 - 32*j -: 32];
            for (int t = 0; t < 64; t++) begin
                s1 = ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25);
                t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sihs_pkg::RK[t] + w[t];
                s0 = ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22);
                t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int j = 0; j < 8; j++)
                chain[255 - 32*j -: 32] = chain[255 - 32*j -: 32] + v[j];
            return chain;
        endfunction

        // Compute the expected IV and bright value for one counter
        function iv_result_t predict_iv(logic [63:0] ctr);
            iv_result_t   r;
            logic [127:0] amb;
            logic [127:0] bright;
            logic [511:0] pad_blk;
            logic [255:0] inner;
            logic [255:0] outer;
            logic [7:0]   v;
            for (int i = 0; i < 16; i++) begin
                v = nonce[127 - 8*i -: 8] - 8'(i) - 8'h27;
                amb[127 - 8*i -: 8] = v ^ AMB_TAB[i];
                v = morning[127 - 8*i -: 8] - 8'(i) + 8'h34;
                bright[127 - 8*i -: 8] = v ^ BRIGHT_TAB[i] ^ nonce[127 - 8*i -: 8];
            end
            // inner hash: ipad block, then ambassador, counter and padding
            pad_blk = {SECRET_KEY, 384'd0} ^ {64{8'h36}};
            inner = sha_block(sihs_pkg::H_INIT, pad_blk);
            inner = sha_block(inner, {amb, ctr, 8'h80, 248'd0, 64'd704});
            // outer hash: opad block, then inner digest and padding
            pad_blk = {SECRET_KEY, 384'd0} ^ {64{8'h5c}};
            outer = sha_block(sihs_pkg::H_INIT, pad_blk);
            outer = sha_block(outer, {inner, 8'h80, 184'd0, 64'd768});
            r.iv_hi     = outer[255:192];
            r.iv_lo     = outer[191:128];
            r.bright_hi = bright[127:64];
            r.bright_lo = bright[63:0];
            return r;
        endfunction

        function void note_command(logic [63:0] ctr);
            pending_ivs.push_back(predict_iv(ctr));
        endfunction

        function void check_result(iv_result_t got);
            iv_result_t exp;
            if (pending_ivs.size() == 0) begin
                $display("%0t: unexpected result iv_hi=%h", $time, got.iv_hi);
                errors++;
                return;
            end
            exp = pending_ivs.pop_front();
            checked++;
            if (got.iv_hi !== exp.iv_hi) begin
                $display("%0t: iv_hi expected %h actual %h", $time, exp.iv_hi, got.iv_hi);
                errors++;
            end
            if (got.iv_lo !== exp.iv_lo) begin
                $display("%0t: iv_lo expected %h actual %h", $time, exp.iv_lo, got.iv_lo);
                errors++;
            end
            if (got.bright_hi !== exp.bright_hi) begin
                $display("%0t: bright_hi expected %h actual %h", $time,
                         exp.bright_hi, got.bright_hi);
                errors++;
            end
            if (got.bright_lo !== exp.bright_lo) begin
                $display("%0t: bright_lo expected %h actual %h", $time,
                         exp.bright_lo, got.bright_lo);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        start = 1'b0;
    logic [63:0] counter = '0;
    logic        busy;
    logic        done;
    logic [63:0] iv_hi, iv_lo, bright_hi, bright_lo;

    iv_scoreboard sb = new();
    int           cycles = 0;
    int           sender_idle_pct = 0;
    int           sent = 0;

    session_iv_hmac_sha256 dut (.*);

    always #5 clk = ~clk;

    // Abort on a hung block
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Capture each strobed result
    always @(posedge clk)
    begin
        iv_result_t got;
        if (rst_n && done) begin
            got.iv_hi     = iv_hi;
            got.iv_lo     = iv_lo;
            got.bright_hi = bright_hi;
            got.bright_lo = bright_lo;
            sb.check_result(got);
        end
    end

    // APB write: setup cycle, then access cycle
    task automatic apb_write(logic [1:0] idx, logic [63:0] val);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        sb.write_reg(idx, val);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Drain: wait for every expected IV, then let the block settle
    task automatic wait_idle();
        while (sb.pending_ivs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_regs(logic [63:0] nh, logic [63:0] nl,
                             logic [63:0] mh, logic [63:0] ml);
        wait_idle();
        apb_write(sihs_pkg::REG_NONCE_HI, nh);
        apb_write(sihs_pkg::REG_NONCE_LO, nl);
        apb_write(sihs_pkg::REG_MORNING_HI, mh);
        apb_write(sihs_pkg::REG_MORNING_LO, ml);
    endtask

    // Issue one counter command and hold it until accepted
    task automatic send_counter(logic [63:0] ctr);
        while ($urandom_range(99) < sender_idle_pct)
            @(negedge clk);
        @(negedge clk);
        start   = 1'b1;
        counter = ctr;
        do @(posedge clk); while (busy);
        sb.note_command(ctr);
        sent++;
        @(negedge clk);
        start   = 1'b0;
        counter = {$urandom, $urandom};
    endtask

    function automatic logic [63:0] rand_word(int kind);
        case (kind)
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial
    begin
        sb.clear_regs();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: counter extremes under reset, all-ones and mixed configuration
        send_counter(64'd0);
        send_counter('1);
        send_counter(64'd1);
        send_counter(64'h8000_0000_0000_0000);
        send_counter(64'h7fff_ffff_ffff_ffff);
        send_counter(64'h5555_aaaa_5555_aaaa);
        load_regs('1, '1, '1, '1);
        send_counter(64'd0);
        send_counter('1);
        send_counter(64'haaaa_5555_aaaa_5555);
        load_regs('0, '1, '1, '0);
        send_counter(64'h0123_4567_89ab_cdef);
        send_counter(64'hfedc_ba98_7654_3210);

        // Random phases with varying sender gaps and register settings
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph % 4)
                0: sender_idle_pct = 0;
                1: sender_idle_pct = 67;
                2: sender_idle_pct = 0;
                default: sender_idle_pct = 33;
            endcase
            load_regs(rand_word($urandom_range(4)), rand_word($urandom_range(4)),
                      rand_word($urandom_range(4)), rand_word($urandom_range(4)));
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n == ITEMS_PER_PHASE / 2)
                    wait_idle();
                case ($urandom_range(9))
                    0:       send_counter(rand_word($urandom_range(1)));
                    1:       send_counter(64'd1 << $urandom_range(63));
                    default: send_counter({$urandom, $urandom});
                endcase
            end
        end

        while (sb.pending_ivs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d counter commands, %0d IVs checked, across %0d register settings",
                 sent, sb.checked, NUM_PHASES + 3);
        $display("with and without sender gaps and with full drains between phases");
        if (sb.errors == 0 && sb.pending_ivs.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
